[hw/rtl/ray_closest_hit_search_assert.svh]
// assertion macros for the closest hit search block
`ifndef RAY_CLOSEST_HIT_SEARCH_ASSERT_SVH
`define RAY_CLOSEST_HIT_SEARCH_ASSERT_SVH

`ifndef SYNTH
`define RCH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rch assertion failed");
`define RCH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rch assertion failed");
`else
`define RCH_ASSERT(lbl, clk, rst_n, prop)
`define RCH_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/rch_pkg.sv]
// types, constants, saturation helpers and micro-programs of the closest hit search
`default_nettype none
package rch_pkg;

    localparam int WORDS_PER_OBJECT = 7;
    localparam int SCRATCH_WORDS    = 16;
    localparam int SQRT_STEPS       = 24;
    localparam int DIV_STEPS        = 48;

    localparam logic [1:0] KIND_SPHERE   = 2'd0;
    localparam logic [1:0] KIND_PLANE    = 2'd1;
    localparam logic [1:0] KIND_CYLINDER = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [2:0] CFG_SCENE_KIND   = 3'd0;
    localparam logic [2:0] CFG_OBJECT_COUNT = 3'd1;
    localparam logic [2:0] CFG_HIT_EPSILON  = 3'd2;
    localparam logic [2:0] CFG_MAX_DISTANCE = 3'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_MACF, OP_MAC, OP_MACL,
        OP_SQRT, OP_DIV,
        OP_MISS_NEG, OP_MISS_ZERO, OP_MISS_LT_EPS, OP_MISS_LE_EPS, OP_MISS_SAME,
        OP_MISS, OP_SEL_POS, OP_SEL_GE_EPS, OP_END
    } t_op;

    // operand: top bit picks an object word, else a scratch word
    typedef logic [4:0] t_opnd;

    typedef struct packed {
        t_op        op;
        logic [3:0] dst;
        t_opnd      a;
        t_opnd      b;
    } t_uop;

    // scratch words: 0-2 origin, 3-5 direction, rest temporaries
    localparam t_opnd S0 = 5'd0,  S1 = 5'd1,  S2 = 5'd2,  S3 = 5'd3;
    localparam t_opnd S4 = 5'd4,  S5 = 5'd5,  S6 = 5'd6,  S7 = 5'd7;
    localparam t_opnd S8 = 5'd8,  S9 = 5'd9,  S10 = 5'd10, S11 = 5'd11;
    localparam t_opnd S12 = 5'd12, S13 = 5'd13, S14 = 5'd14, S15 = 5'd15;
    // object words: 0-2 position, 3-5 normal or axis, 6 radius
    localparam t_opnd W0 = 5'h10, W1 = 5'h11, W2 = 5'h12, W3 = 5'h13;
    localparam t_opnd W4 = 5'h14, W5 = 5'h15, W6 = 5'h16;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_uop u(input t_op op, input t_opnd d, input t_opnd a,
                               input t_opnd b);
        t_uop r;
        r.op  = op;
        r.dst = d[3:0];
        r.a   = a;
        r.b   = b;
        return r;
    endfunction

    // micro-program of one object test, per kind
    function automatic t_uop ucode(input logic [1:0] kind, input logic [5:0] pc);
        t_uop r;
        r = u(OP_MISS, S0, S0, S0);
        case (kind)
            KIND_SPHERE: begin
                case (pc)
                    6'd0:  r = u(OP_SUB, S6, S0, W0);
                    6'd1:  r = u(OP_SUB, S7, S1, W1);
                    6'd2:  r = u(OP_SUB, S8, S2, W2);
                    6'd3:  r = u(OP_MACF, S0, S3, S3);
                    6'd4:  r = u(OP_MAC, S0, S4, S4);
                    6'd5:  r = u(OP_MACL, S9, S5, S5);
                    6'd6:  r = u(OP_MACF, S0, S6, S3);
                    6'd7:  r = u(OP_MAC, S0, S7, S4);
                    6'd8:  r = u(OP_MACL, S10, S8, S5);
                    6'd9:  r = u(OP_MACF, S0, S6, S6);
                    6'd10: r = u(OP_MAC, S0, S7, S7);
                    6'd11: r = u(OP_MACL, S11, S8, S8);
                    6'd12: r = u(OP_MUL, S12, W6, W6);
                    6'd13: r = u(OP_SUB, S11, S11, S12);
                    6'd14: r = u(OP_MUL, S12, S10, S10);
                    6'd15: r = u(OP_MUL, S13, S9, S11);
                    6'd16: r = u(OP_SUB, S12, S12, S13);
                    6'd17: r = u(OP_MISS_NEG, S0, S12, S0);
                    6'd18: r = u(OP_MISS_ZERO, S0, S9, S0);
                    6'd19: r = u(OP_SQRT, S13, S12, S0);
                    6'd20: r = u(OP_NEG, S14, S10, S0);
                    6'd21: r = u(OP_ADD, S15, S14, S13);
                    6'd22: r = u(OP_DIV, S15, S15, S9);
                    6'd23: r = u(OP_SUB, S14, S14, S13);
                    6'd24: r = u(OP_DIV, S14, S14, S9);
                    6'd25: r = u(OP_MISS_LE_EPS, S0, S15, S0);
                    6'd26: r = u(OP_SEL_POS, S14, S14, S15);
                    6'd27: r = u(OP_END, S0, S14, S0);
                    default: r = u(OP_MISS, S0, S0, S0);
                endcase
            end
            KIND_PLANE: begin
                case (pc)
                    6'd0:  r = u(OP_SUB, S6, S0, W0);
                    6'd1:  r = u(OP_SUB, S7, S1, W1);
                    6'd2:  r = u(OP_SUB, S8, S2, W2);
                    6'd3:  r = u(OP_MACF, S0, S3, W3);
                    6'd4:  r = u(OP_MAC, S0, S4, W4);
                    6'd5:  r = u(OP_MACL, S9, S5, W5);
                    6'd6:  r = u(OP_MACF, S0, S6, W3);
                    6'd7:  r = u(OP_MAC, S0, S7, W4);
                    6'd8:  r = u(OP_MACL, S10, S8, W5);
                    6'd9:  r = u(OP_MISS_ZERO, S0, S9, S0);
                    6'd10: r = u(OP_MISS_SAME, S0, S9, S10);
                    6'd11: r = u(OP_NEG, S11, S10, S0);
                    6'd12: r = u(OP_DIV, S11, S11, S9);
                    6'd13: r = u(OP_MISS_LE_EPS, S0, S11, S0);
                    6'd14: r = u(OP_END, S0, S11, S0);
                    default: r = u(OP_MISS, S0, S0, S0);
                endcase
            end
            KIND_CYLINDER: begin
                case (pc)
                    6'd0:  r = u(OP_SUB, S6, S0, W0);
                    6'd1:  r = u(OP_SUB, S7, S1, W1);
                    6'd2:  r = u(OP_SUB, S8, S2, W2);
                    6'd3:  r = u(OP_MACF, S0, S6, W3);
                    6'd4:  r = u(OP_MAC, S0, S7, W4);
                    6'd5:  r = u(OP_MACL, S9, S8, W5);
                    6'd6:  r = u(OP_MACF, S0, S3, W3);
                    6'd7:  r = u(OP_MAC, S0, S4, W4);
                    6'd8:  r = u(OP_MACL, S10, S5, W5);
                    6'd9:  r = u(OP_MACF, S0, S3, S3);
                    6'd10: r = u(OP_MAC, S0, S4, S4);
                    6'd11: r = u(OP_MACL, S11, S5, S5);
                    6'd12: r = u(OP_MUL, S12, S10, S10);
                    6'd13: r = u(OP_SUB, S11, S11, S12);
                    6'd14: r = u(OP_MACF, S0, S3, S6);
                    6'd15: r = u(OP_MAC, S0, S4, S7);
                    6'd16: r = u(OP_MACL, S12, S5, S8);
                    6'd17: r = u(OP_MUL, S13, S10, S9);
                    6'd18: r = u(OP_SUB, S12, S12, S13);
                    6'd19: r = u(OP_ADD, S12, S12, S12);
                    6'd20: r = u(OP_MACF, S0, S6, S6);
                    6'd21: r = u(OP_MAC, S0, S7, S7);
                    6'd22: r = u(OP_MACL, S13, S8, S8);
                    6'd23: r = u(OP_MUL, S14, S9, S9);
                    6'd24: r = u(OP_SUB, S13, S13, S14);
                    6'd25: r = u(OP_MUL, S14, W6, W6);
                    6'd26: r = u(OP_SUB, S13, S13, S14);
                    6'd27: r = u(OP_MUL, S14, S11, S13);
                    6'd28: r = u(OP_ADD, S14, S14, S14);
                    6'd29: r = u(OP_ADD, S14, S14, S14);
                    6'd30: r = u(OP_MUL, S13, S12, S12);
                    6'd31: r = u(OP_SUB, S13, S13, S14);
                    6'd32: r = u(OP_MISS_LT_EPS, S0, S13, S0);
                    6'd33: r = u(OP_ADD, S11, S11, S11);
                    6'd34: r = u(OP_MISS_ZERO, S0, S11, S0);
                    6'd35: r = u(OP_SQRT, S14, S13, S0);
                    6'd36: r = u(OP_NEG, S12, S12, S0);
                    6'd37: r = u(OP_ADD, S15, S12, S14);
                    6'd38: r = u(OP_DIV, S15, S15, S11);
                    6'd39: r = u(OP_SUB, S12, S12, S14);
                    6'd40: r = u(OP_DIV, S12, S12, S11);
                    6'd41: r = u(OP_MISS_LE_EPS, S0, S15, S0);
                    6'd42: r = u(OP_SEL_GE_EPS, S12, S12, S15);
                    6'd43: r = u(OP_END, S0, S12, S0);
                    default: r = u(OP_MISS, S0, S0, S0);
                endcase
            end
            default: r = u(OP_MISS, S0, S0, S0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ray_closest_hit_search.sv]
// closest hit search of a ray over stored spheres, planes or cylinders
`default_nettype none
`include "ray_closest_hit_search_assert.svh"
// A beat with tuser 0 stores one object word; a beat with tuser 1 runs a ray
// query and gives one result beat. A query copies the ray into scratch, then
// tests each object under a micro-sequencer on one shared datapath: every
// micro-op has a read state and an execute state, a product then a state that
// floors it and stores or accumulates it, and a square root or a division an
// iteration state and then a write-back state. The test of one object ends
// early when a miss test hits, else at the end micro-op of its kind.
// The word store and scratch share one memory with two read ports and one
// write port, which sets the one-operation-at-a-time pace. Object words are
// not cleared by reset and must be written before they are searched.
module ray_closest_hit_search
    import rch_pkg::*;
#(
    parameter int MAX_OBJECTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [30:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // object_slot, word_select, word_value, origin_x/y/z, ray_dir_x/y/z, pad
    input  wire logic [231:0] s_axis_tdata,
    // action
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit_index, hit_distance, pad
    output logic [39:0]       m_axis_tdata,
    // hit
    output logic              m_axis_tuser
);

    localparam int SCR_BASE = MAX_OBJECTS * WORDS_PER_OBJECT;
    localparam int DEPTH    = SCR_BASE + SCRATCH_WORDS;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(MAX_OBJECTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_OBJ, ST_FETCH, ST_EXEC, ST_MUL, ST_ITER, ST_FIN, ST_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_scene, n_scene;
    logic [4:0]         r_count, n_count;
    logic [15:0]        r_eps, n_eps;
    logic [30:0]        r_maxd, n_maxd;
    logic signed [31:0] r_ray [6];
    logic               n_ray_load;
    logic [2:0]         r_lcnt, n_lcnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_base, n_base;
    logic [5:0]         r_pc, n_pc;
    logic [5:0]         r_cnt, n_cnt;
    logic signed [63:0] r_prod, n_prod;
    logic signed [49:0] r_acc, n_acc;
    logic [47:0]        r_n, n_n, r_r, n_r, r_bit, n_bit;
    logic [31:0]        r_den, n_den;
    logic               r_neg, n_neg;
    logic signed [31:0] r_close, n_close;
    logic [3:0]         r_best, n_best;
    logic               r_found, n_found;
    logic               r_m_valid, n_m_valid;
    logic               r_m_hit, n_m_hit;
    logic [3:0]         r_m_idx, n_m_idx;
    logic [30:0]        r_m_dist, n_m_dist;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_a, r_rd_b;
    logic [AW-1:0]      ra_a, ra_b, wa;
    logic               we;
    logic signed [31:0] wd;

    t_uop               uop;
    logic               in_acc;
    logic [3:0]         in_slot;
    logic [2:0]         in_sel;
    logic signed [31:0] eps32;
    logic signed [32:0] sum_ab, dif_ab;
    logic signed [47:0] prod_f;
    logic signed [49:0] acc_new;
    logic [47:0]        sq_rb;
    logic [32:0]        dv_sh;
    logic [31:0]        a_mag, b_mag;
    logic signed [31:0] div_res;
    logic [8:0]         eff_count;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_slot = s_axis_tdata[3:0];
    assign in_sel  = s_axis_tdata[6:4];
    assign uop     = ucode(r_scene, r_pc);
    assign eps32   = {16'd0, r_eps};
    assign sum_ab  = 33'(r_rd_a) + 33'(r_rd_b);
    assign dif_ab  = 33'(r_rd_a) - 33'(r_rd_b);
    assign prod_f  = r_prod[63:16];
    assign acc_new = ((uop.op == OP_MACF) ? 50'sd0 : r_acc) + 50'(prod_f);
    assign sq_rb   = r_r + r_bit;
    assign dv_sh   = {r_r[31:0], r_n[47]};
    assign a_mag   = r_rd_a[31] ? 32'(-r_rd_a) : r_rd_a;
    assign b_mag   = r_rd_b[31] ? 32'(-r_rd_b) : r_rd_b;
    assign eff_count = (9'(r_count) > 9'(MAX_OBJECTS)) ? 9'(MAX_OBJECTS) : 9'(r_count);

    // signed quotient from magnitude, with saturation
    always_comb begin
        if (!r_neg) begin
            div_res = (r_n > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : r_n[31:0];
        end else begin
            div_res = (r_n > 48'h80000000) ? 32'sh80000000 : 32'(-r_n[31:0]);
        end
    end

    // operand read addresses
    always_comb begin
        ra_a = uop.a[4] ? r_base + AW'(uop.a[2:0]) : AW'(SCR_BASE) + AW'(uop.a[3:0]);
        ra_b = uop.b[4] ? r_base + AW'(uop.b[2:0]) : AW'(SCR_BASE) + AW'(uop.b[3:0]);
    end

    // sequencer and datapath next state
    always_comb begin
        n_state = r_state;  n_scene = r_scene;  n_count = r_count;
        n_eps = r_eps;      n_maxd = r_maxd;    n_ray_load = 1'b0;
        n_lcnt = r_lcnt;    n_idx = r_idx;      n_base = r_base;
        n_pc = r_pc;        n_cnt = r_cnt;      n_prod = r_prod;
        n_acc = r_acc;      n_n = r_n;          n_r = r_r;
        n_bit = r_bit;      n_den = r_den;      n_neg = r_neg;
        n_close = r_close;  n_best = r_best;    n_found = r_found;
        n_m_valid = r_m_valid; n_m_hit = r_m_hit;
        n_m_idx = r_m_idx;  n_m_dist = r_m_dist;
        we = 1'b0;
        wa = AW'(SCR_BASE) + AW'(uop.dst);
        wd = r_rd_a;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCENE_KIND:   n_scene = i_cfg_data[1:0];
                CFG_OBJECT_COUNT: n_count = i_cfg_data[4:0];
                CFG_HIT_EPSILON:  n_eps   = i_cfg_data[15:0];
                CFG_MAX_DISTANCE: n_maxd  = i_cfg_data;
                default: ;
            endcase
        end

        // result beat taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == ACT_WRITE) begin
                        if (in_sel < 3'(WORDS_PER_OBJECT) && 9'(in_slot) < 9'(MAX_OBJECTS)) begin
                            we = 1'b1;
                            wa = AW'({in_slot, 3'b000}) - AW'(in_slot) + AW'(in_sel);
                            wd = s_axis_tdata[38:7];
                        end
                    end else begin
                        n_ray_load = 1'b1;
                        n_lcnt  = 3'd0;
                        n_idx   = '0;
                        n_base  = '0;
                        n_close = {1'b0, r_maxd};
                        n_best  = 4'd0;
                        n_found = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            // copy the ray into scratch
            ST_LOAD: begin
                we = 1'b1;
                wa = AW'(SCR_BASE) + AW'(r_lcnt);
                wd = r_ray[r_lcnt];
                n_lcnt = r_lcnt + 3'd1;
                if (r_lcnt == 3'd5) begin
                    n_state = ST_OBJ;
                end
            end
            ST_OBJ: begin
                if (r_scene == KIND_NONE || 9'(r_idx) >= eff_count) begin
                    n_state = ST_DONE;
                end else begin
                    n_pc = 6'd0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_pc = r_pc + 6'd1;
                n_state = ST_FETCH;
                case (uop.op)
                    OP_ADD: begin
                        we = 1'b1;
                        wd = sat32(50'(sum_ab));
                    end
                    OP_SUB: begin
                        we = 1'b1;
                        wd = sat32(50'(dif_ab));
                    end
                    OP_NEG: begin
                        we = 1'b1;
                        wd = sat32(-50'(r_rd_a));
                    end
                    OP_MUL, OP_MACF, OP_MAC, OP_MACL: begin
                        n_prod = r_rd_a * r_rd_b;
                        n_pc = r_pc;
                        n_state = ST_MUL;
                    end
                    OP_SQRT: begin
                        n_n = (r_rd_a > 32'sd0) ? {r_rd_a, 16'd0} : 48'd0;
                        n_r = 48'd0;
                        n_bit = 48'd1 << 46;
                        n_cnt = 6'd0;
                        n_pc = r_pc;
                        n_state = ST_ITER;
                    end
                    OP_DIV: begin
                        n_n = {a_mag, 16'd0};
                        n_r = 48'd0;
                        n_den = b_mag;
                        n_neg = r_rd_a[31] ^ r_rd_b[31];
                        n_cnt = 6'd0;
                        n_pc = r_pc;
                        n_state = ST_ITER;
                    end
                    OP_SEL_POS: begin
                        we = 1'b1;
                        wd = (r_rd_a > 32'sd0) ? r_rd_a : r_rd_b;
                    end
                    OP_SEL_GE_EPS: begin
                        we = 1'b1;
                        wd = (r_rd_a >= eps32) ? r_rd_a : r_rd_b;
                    end
                    default: begin
                        // miss tests and the end of an object
                        if ((uop.op == OP_MISS)
                            || (uop.op == OP_MISS_NEG && r_rd_a < 32'sd0)
                            || (uop.op == OP_MISS_ZERO && r_rd_a == 32'sd0)
                            || (uop.op == OP_MISS_LT_EPS && r_rd_a < eps32)
                            || (uop.op == OP_MISS_LE_EPS && r_rd_a <= eps32)
                            || (uop.op == OP_MISS_SAME && r_rd_a != 32'sd0
                                && r_rd_b != 32'sd0 && r_rd_a[31] == r_rd_b[31])
                            || (uop.op == OP_END)) begin
                            if (uop.op == OP_END && r_rd_a < r_close) begin
                                n_close = r_rd_a;
                                n_best  = 4'(r_idx);
                                n_found = 1'b1;
                            end
                            n_idx  = r_idx + CW'(1);
                            n_base = r_base + AW'(WORDS_PER_OBJECT);
                            n_state = ST_OBJ;
                        end
                    end
                endcase
            end
            // floor the product, then store or accumulate
            ST_MUL: begin
                n_pc = r_pc + 6'd1;
                n_state = ST_FETCH;
                case (uop.op)
                    OP_MUL: begin
                        we = 1'b1;
                        wd = sat32(50'(prod_f));
                    end
                    OP_MACL: begin
                        we = 1'b1;
                        wd = sat32(acc_new);
                    end
                    default: n_acc = acc_new;
                endcase
            end
            // one root or quotient bit a cycle
            ST_ITER: begin
                n_cnt = r_cnt + 6'd1;
                if (uop.op == OP_SQRT) begin
                    if (r_n >= sq_rb) begin
                        n_n = r_n - sq_rb;
                        n_r = (r_r >> 1) + r_bit;
                    end else begin
                        n_r = r_r >> 1;
                    end
                    n_bit = r_bit >> 2;
                    if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                        n_state = ST_FIN;
                    end
                end else begin
                    if (dv_sh >= {1'b0, r_den}) begin
                        n_r = 48'(dv_sh - {1'b0, r_den});
                        n_n = {r_n[46:0], 1'b1};
                    end else begin
                        n_r = 48'(dv_sh);
                        n_n = {r_n[46:0], 1'b0};
                    end
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                we = 1'b1;
                wd = (uop.op == OP_SQRT) ? r_r[31:0] : div_res;
                n_pc = r_pc + 6'd1;
                n_state = ST_FETCH;
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_hit   = r_found;
                    n_m_idx   = r_found ? r_best : 4'd0;
                    n_m_dist  = r_close[30:0];
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scene   <= KIND_SPHERE;
            r_count   <= 5'd0;
            r_eps     <= 16'd7;
            r_maxd    <= 31'h7FFFFFFF;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scene   <= n_scene;
            r_count   <= n_count;
            r_eps     <= n_eps;
            r_maxd    <= n_maxd;
            r_m_valid <= n_m_valid;
        end
        if (n_ray_load) begin
            r_ray[0] <= s_axis_tdata[70:39];
            r_ray[1] <= s_axis_tdata[102:71];
            r_ray[2] <= s_axis_tdata[134:103];
            r_ray[3] <= s_axis_tdata[166:135];
            r_ray[4] <= s_axis_tdata[198:167];
            r_ray[5] <= s_axis_tdata[230:199];
        end
        r_lcnt  <= n_lcnt;   r_idx  <= n_idx;   r_base <= n_base;
        r_pc    <= n_pc;     r_cnt  <= n_cnt;   r_prod <= n_prod;
        r_acc   <= n_acc;    r_n    <= n_n;     r_r    <= n_r;
        r_bit   <= n_bit;    r_den  <= n_den;   r_neg  <= n_neg;
        r_close <= n_close;  r_best <= n_best;  r_found <= n_found;
        r_m_hit <= n_m_hit;  r_m_idx <= n_m_idx; r_m_dist <= n_m_dist;
    end

    // word store and scratch, registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_a <= r_mem[ra_a];
        r_rd_b <= r_mem[ra_b];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_dist, r_m_idx};
    assign m_axis_tuser  = r_m_hit;

    `RCH_ASSERT(a_miss_index_zero, i_clk, i_rst_n, r_m_valid && !r_m_hit |-> r_m_idx == 4'd0)
    `RCH_ASSERT(a_iter_bound, i_clk, i_rst_n, r_state == ST_ITER |-> r_cnt < 6'(DIV_STEPS))
    `RCH_ASSERT(a_query_loads, i_clk, i_rst_n, in_acc && s_axis_tuser == ACT_QUERY |=> r_state == ST_LOAD)
    `RCH_ASSERT_ALWAYS(a_reset_no_beat, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule
`default_nettype wire
